FILE: hw/rtl/uges_pkg.sv
package uges_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int VERT_W = 6;
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int DEG_W = 6;
   localparam int EDGE_W = 11;
   localparam int KIND_W = 2;
   localparam int VCOUNT_W = 7;

   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(64);
   localparam logic [CNT_W-1:0] VCOUNT_MAX = CNT_W'(MAX_VERTICES);

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;

   typedef struct packed {
      logic clear;
      logic capture;
      logic rd_a;
      logic upd_a;
      logic upd_b;
      logic scan_init;
      logic scan_rd;
      logic load_rsp;
   } uges_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic bad;
      logic scan_done;
      logic rsp_busy;
   } uges_status_type;

endpackage

FILE: hw/rtl/uges_ctrl.sv
module uges_ctrl import uges_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  uges_status_type status,
   output uges_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_A,
      ST_UPD_A,
      ST_UPD_B,
      ST_SCAN_INIT,
      ST_SCAN,
      ST_SCAN_END,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_READ_A;
            end
         end
         ST_READ_A: begin
            cmd.rd_a = 1'b1;
            state_in = status.bad ? ST_SCAN_INIT : ST_UPD_A;
         end
         ST_UPD_A: begin
            cmd.upd_a = 1'b1;
            state_in = ST_UPD_B;
         end
         ST_UPD_B: begin
            cmd.upd_b = 1'b1;
            state_in = ST_SCAN_INIT;
         end
         ST_SCAN_INIT: begin
            cmd.scan_init = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_SCAN_END;
            else cmd.scan_rd = 1'b1;
         end
         ST_SCAN_END: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

endmodule

FILE: hw/rtl/uges_datapath.sv
module uges_datapath import uges_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  uges_cmd_type        cmd,
   output uges_status_type     status,
   input  logic                csr_write_enable,
   input  logic [VCOUNT_W-1:0] csr_write_data,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [VERT_W-1:0]   req_first_vertex,
   input  logic [VERT_W-1:0]   req_second_vertex,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_edge_was_present,
   output logic                rsp_graph_changed,
   output logic                rsp_bad_vertex,
   output logic [EDGE_W-1:0]   rsp_total_edges,
   output logic [EDGE_W-1:0]   rsp_lowest_degree,
   output logic [DEG_W-1:0]    rsp_highest_degree
);

   logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
   logic [DEG_W-1:0]        deg_mem [MAX_VERTICES];

   logic [VCOUNT_W-1:0]     vcount_ff;
   logic [EDGE_W-1:0]       edge_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    cmp_valid_ff;
   logic                    rsp_valid_ff;
   logic [KIND_W-1:0]       kind_ff;
   logic [VERT_W-1:0]       a_ff, b_ff;
   logic                    present_ff, change_ff, bad_ff;
   logic [EDGE_W-1:0]       lo_ff;
   logic [DEG_W-1:0]        hi_ff;
   logic [MAX_VERTICES-1:0] rd_row_ff;
   logic [DEG_W-1:0]        rd_deg_ff;

   logic                    r_present_ff, r_changed_ff, r_bad_ff;
   logic [EDGE_W-1:0]       r_total_ff, r_lo_ff;
   logic [DEG_W-1:0]        r_hi_ff;

   logic [CNT_W-1:0]        n_used;
   logic                    bad;
   logic                    present_now, change_now, is_insert;
   logic [VERT_W-1:0]       rd_addr, wr_addr;
   logic                    wr_en;
   logic [MAX_VERTICES-1:0] wr_row, bit_a, bit_b;
   logic [DEG_W-1:0]        deg_step;

   assign n_used = (vcount_ff > VCOUNT_W'(MAX_VERTICES)) ? VCOUNT_MAX : CNT_W'(vcount_ff);
   assign bad = ({1'b0, a_ff} >= n_used) || ({1'b0, b_ff} >= n_used);

   assign is_insert = (kind_ff == KIND_INSERT);
   assign present_now = rd_row_ff[b_ff];
   assign change_now = (is_insert && !present_now && (a_ff != b_ff))
                     || ((kind_ff == KIND_REMOVE) && present_now);
   assign bit_a = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << a_ff;
   assign bit_b = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << b_ff;
   assign deg_step = is_insert ? rd_deg_ff + DEG_W'(1) : rd_deg_ff - DEG_W'(1);

   always_comb begin
      rd_addr = a_ff;
      if (cmd.upd_a) rd_addr = b_ff;
      if (cmd.scan_rd) rd_addr = cnt_ff[VERT_W-1:0];
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = a_ff;
      wr_row = rd_row_ff ^ bit_b;
      if (cmd.clear) begin
         wr_en = 1'b1;
         wr_addr = cnt_ff[VERT_W-1:0];
         wr_row = '0;
      end else if (cmd.upd_a) begin
         wr_en = change_now;
      end else if (cmd.upd_b) begin
         wr_en = change_ff;
         wr_addr = b_ff;
         wr_row = rd_row_ff ^ bit_a;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         adj_mem[wr_addr] <= wr_row;
         deg_mem[wr_addr] <= cmd.clear ? '0 : deg_step;
      end
      rd_row_ff <= adj_mem[rd_addr];
      rd_deg_ff <= deg_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_RESET;
         edge_ff <= '0;
         cnt_ff <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) vcount_ff <= csr_write_data;
         if (cmd.upd_b && change_ff) begin
            edge_ff <= is_insert ? edge_ff + EDGE_W'(1) : edge_ff - EDGE_W'(1);
         end
         if (cmd.clear || cmd.scan_rd) cnt_ff <= cnt_ff + CNT_W'(1);
         else if (cmd.scan_init) cnt_ff <= '0;
         cmp_valid_ff <= cmd.scan_rd;
         if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         a_ff <= req_first_vertex;
         b_ff <= req_second_vertex;
         present_ff <= 1'b0;
         change_ff <= 1'b0;
      end
      if (cmd.rd_a) bad_ff <= bad;
      if (cmd.upd_a) begin
         present_ff <= present_now;
         change_ff <= change_now;
      end
      if (cmd.scan_init) begin
         lo_ff <= edge_ff;
         hi_ff <= '0;
      end else if (cmp_valid_ff) begin
         if (EDGE_W'(rd_deg_ff) < lo_ff) lo_ff <= EDGE_W'(rd_deg_ff);
         if (rd_deg_ff > hi_ff) hi_ff <= rd_deg_ff;
      end
      if (cmd.load_rsp) begin
         r_present_ff <= present_ff;
         r_changed_ff <= change_ff;
         r_bad_ff <= bad_ff;
         r_total_ff <= edge_ff;
         r_lo_ff <= lo_ff;
         r_hi_ff <= hi_ff;
      end
   end

   assign status.clear_last = (cnt_ff[VERT_W-1:0] == VERT_W'(MAX_VERTICES - 1));
   assign status.bad = bad;
   assign status.scan_done = (cnt_ff == n_used);
   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_edge_was_present = r_present_ff;
   assign rsp_graph_changed = r_changed_ff;
   assign rsp_bad_vertex = r_bad_ff;
   assign rsp_total_edges = r_total_ff;
   assign rsp_lowest_degree = r_lo_ff;
   assign rsp_highest_degree = r_hi_ff;

endmodule

FILE: hw/rtl/undirected_graph_edge_store.sv
// Undirected graph adjacency store: each transfer inserts, removes or queries one edge
// and returns one result with the edge's prior presence, the change flag, the edge
// count and the min/max degree over the vertices in use. After reset the block clears
// every row and degree counter of its memories and holds req_ready low meanwhile.
// From transfer to result an item passes a degree scan over n = min(vertex_count, 64)
// vertices, which reads one counter per cycle through the single read port of the
// degree memory; a bad vertex skips the update states ST_UPD_A and ST_UPD_B.
// vertex_count must be written only while the block is idle; the block does not enforce it.
module undirected_graph_edge_store import uges_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [VCOUNT_W-1:0] csr_write_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [VERT_W-1:0]   req_first_vertex,
   input  logic [VERT_W-1:0]   req_second_vertex,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_edge_was_present,
   output logic                rsp_graph_changed,
   output logic                rsp_bad_vertex,
   output logic [EDGE_W-1:0]   rsp_total_edges,
   output logic [EDGE_W-1:0]   rsp_lowest_degree,
   output logic [DEG_W-1:0]    rsp_highest_degree
);

   uges_cmd_type    cmd;
   uges_status_type status;

   uges_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   uges_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_kind             (req_kind),
      .req_first_vertex     (req_first_vertex),
      .req_second_vertex    (req_second_vertex),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_edge_was_present (rsp_edge_was_present),
      .rsp_graph_changed    (rsp_graph_changed),
      .rsp_bad_vertex       (rsp_bad_vertex),
      .rsp_total_edges      (rsp_total_edges),
      .rsp_lowest_degree    (rsp_lowest_degree),
      .rsp_highest_degree   (rsp_highest_degree)
   );

endmodule

FILE: hw/rtl/uges_checker.sv
module uges_checker import uges_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_edge_was_present,
   input logic              rsp_graph_changed,
   input logic              rsp_bad_vertex,
   input logic [EDGE_W-1:0] rsp_total_edges,
   input logic [EDGE_W-1:0] rsp_lowest_degree,
   input logic [DEG_W-1:0]  rsp_highest_degree
);

   a_bad_no_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_vertex |-> !rsp_graph_changed && !rsp_edge_was_present)
      else $error("bad vertex reported with edge activity");

   a_hi_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> EDGE_W'(rsp_highest_degree) <= rsp_total_edges)
      else $error("highest degree above edge count");

   a_lo_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_lowest_degree <= rsp_total_edges)
      else $error("lowest degree above edge count");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total_edges))
      else $error("result dropped or changed while stalled");

endmodule

bind undirected_graph_edge_store uges_checker u_uges_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_edge_was_present (rsp_edge_was_present),
   .rsp_graph_changed    (rsp_graph_changed),
   .rsp_bad_vertex       (rsp_bad_vertex),
   .rsp_total_edges      (rsp_total_edges),
   .rsp_lowest_degree    (rsp_lowest_degree),
   .rsp_highest_degree   (rsp_highest_degree)
);
